// ===== sv/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define RBF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rbf_pkg.sv =====
// Package: item types, cell control, constant tables and Q16.16 helpers.
`default_nettype none
package rbf_pkg;

    localparam int NUM_UNITS_DEF = 16;
    localparam int NUM_DIMS_DEF  = 4;

    typedef struct packed {
        logic               command;
        logic [6:0]         word_index;
        logic signed [31:0] word_value;
        logic               last_coordinate;
        logic [1:0]         deriv_axis;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] model_value;
        logic signed [31:0] first_derivative;
        logic signed [31:0] second_derivative;
        logic               overflow_flag;
    } t_out_item;

    // Control broadcast to every cell of the unit ring.
    typedef struct packed {
        logic        we;
        logic [6:0]  idx;
        logic [31:0] data;
        logic        shift;
        logic        rot;
    } t_cell_ctl;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_qres;

    // round(65536 * exp(-n))
    function automatic logic [16:0] exp_tab(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // ceil(2^35 / j): exact floor division by j for 17-bit dividends
    function automatic logic [35:0] recip_tab(input logic [3:0] j);
        logic [35:0] r;
        case (j)
            4'd1:    r = 36'd34359738368;
            4'd2:    r = 36'd17179869184;
            4'd3:    r = 36'd11453246123;
            4'd4:    r = 36'd8589934592;
            4'd5:    r = 36'd6871947674;
            4'd6:    r = 36'd5726623062;
            4'd7:    r = 36'd4908534053;
            4'd8:    r = 36'd4294967296;
            4'd9:    r = 36'd3817748708;
            4'd10:   r = 36'd3435973837;
            default: r = 36'd0;
        endcase
        return r;
    endfunction

    // Q16.16 multiply: magnitude product truncated, saturated with flag
    function automatic t_qres qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] pr;
        logic [47:0] p;
        logic        neg;
        t_qres       r;
        ma  = a[31] ? 32'(-a) : 32'(a);
        mb  = b[31] ? 32'(-b) : 32'(b);
        pr  = ma * mb;
        p   = pr[63:16];
        neg = a[31] ^ b[31];
        r.ovf = 1'b0;
        if (neg) begin
            if (p > 48'h0000_8000_0000) begin
                r.ovf = 1'b1;
                r.val = 32'sh8000_0000;
            end else begin
                r.val = 32'(-p);
            end
        end else begin
            if (p > 48'h0000_7FFF_FFFF) begin
                r.ovf = 1'b1;
                r.val = 32'sh7FFF_FFFF;
            end else begin
                r.val = p[31:0];
            end
        end
        return r;
    endfunction

    // Saturate a 33-bit signed value to 32 bits
    function automatic t_qres sat33(input logic signed [32:0] x);
        t_qres r;
        r.ovf = 1'b0;
        if (x > 33'sh0_7FFF_FFFF) begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end else if (x < -33'sh0_8000_0000) begin
            r.ovf = 1'b1;
            r.val = 32'sh8000_0000;
        end else begin
            r.val = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/gaussian_rbf_network_eval_core.sv =====
// Top level: unit ring, point ring and the shared evaluation sequencer.
// Load item: taken while idle, the block stays ready for the next item.
// Evaluation item: the input stalls while the units are processed in turn; with a valid axis
// each unit also runs the 2/v division and the derivative steps; a nonpositive variance skips it.
// The work is done by the one-bit-a-cycle divider (20 steps for the exponent argument,
// 31 for 2/v) and the ten Horner steps; one unit passes the ring head at a time.
// Reset (synchronous, active low) clears the sequencer and the result valid; stores keep data.
`default_nettype none
module gaussian_rbf_network_eval_core import rbf_pkg::*; #(
    parameter int NUM_UNITS = NUM_UNITS_DEF,
    parameter int NUM_DIMS  = NUM_DIMS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);
    localparam int AW  = 33 + $clog2(NUM_UNITS);
    localparam int D2W = 47 + $clog2(NUM_DIMS);
    localparam int UCW = $clog2(NUM_UNITS + 1);
    localparam int DCW = $clog2(NUM_DIMS + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_UNIT = 5'd1;
    localparam logic [4:0] S_DIFF = 5'd2;
    localparam logic [4:0] S_SQ   = 5'd3;
    localparam logic [4:0] S_CMP  = 5'd4;
    localparam logic [4:0] S_TDIV = 5'd5;
    localparam logic [4:0] S_HMUL = 5'd6;
    localparam logic [4:0] S_HDIV = 5'd7;
    localparam logic [4:0] S_EXP  = 5'd8;
    localparam logic [4:0] S_K    = 5'd9;
    localparam logic [4:0] S_KDIV = 5'd10;
    localparam logic [4:0] S_M0   = 5'd11;
    localparam logic [4:0] S_MD   = 5'd12;
    localparam logic [4:0] S_NEXT = 5'd13;
    localparam logic [4:0] S_FIN  = 5'd14;

    // micro steps of the derivative products
    localparam logic [2:0] M_P   = 3'd0;
    localparam logic [2:0] M_EP  = 3'd1;
    localparam logic [2:0] M_S1  = 3'd2;
    localparam logic [2:0] M_PP  = 3'd3;
    localparam logic [2:0] M_ES  = 3'd4;
    localparam logic [2:0] M_S2  = 3'd5;

    // ---------------------------------------------------------------- state
    logic [4:0]              r_state;
    logic [UCW-1:0]          r_unit;
    logic [DCW-1:0]          r_dim;
    logic [1:0]              r_axis;
    logic                    r_axis_ok;
    logic                    r_flag;
    logic signed [AW-1:0]    r_s0, r_s1, r_s2;
    logic signed [32:0]      r_d;
    logic signed [31:0]      r_diffa;
    logic [D2W-1:0]          r_d2;
    logic [30:0]             r_rem;
    logic [30:0]             r_quo;
    logic [19:0]             r_low;
    logic [4:0]              r_cnt;
    logic [16:0]             r_acc;
    logic [32:0]             r_prod;
    logic [3:0]              r_j;
    logic [16:0]             r_e;
    logic [2:0]              r_step;
    logic signed [31:0]      r_p;
    logic signed [31:0]      r_tmp;
    logic                    r_out_valid;
    t_out_item               r_out;
    logic [NUM_DIMS-1:0][31:0] r_point;

    // ---------------------------------------------------------------- ring
    logic [NUM_UNITS-1:0][NUM_DIMS-1:0][31:0] w_center;
    logic [NUM_UNITS-1:0][31:0]               w_var;
    logic [NUM_UNITS-1:0][31:0]               w_wt;
    t_cell_ctl                                w_ctl;
    logic                                     w_acc_in;

    assign w_acc_in = i_in_valid && !o_in_stall;

    always_comb begin
        w_ctl.we    = w_acc_in && !i_in_item.command;
        w_ctl.idx   = i_in_item.word_index;
        w_ctl.data  = i_in_item.word_value;
        w_ctl.shift = (r_state == S_NEXT);
        w_ctl.rot   = (r_state == S_SQ);
    end

    genvar g;
    generate
        for (g = 0; g < NUM_UNITS; g++) begin : g_cell
            localparam int NB = (g + 1) % NUM_UNITS;
            rbf_cell #(
                .NUM_UNITS (NUM_UNITS),
                .NUM_DIMS  (NUM_DIMS),
                .ID        (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_nb_center (w_center[NB]),
                .i_nb_var    (w_var[NB]),
                .i_nb_wt     (w_wt[NB]),
                .o_center    (w_center[g]),
                .o_var       (w_var[g]),
                .o_wt        (w_wt[g])
            );
        end

        // point ring: write by index while idle, rotate in step with the centers
        for (g = 0; g < NUM_DIMS; g++) begin : g_pt
            localparam int NXT = (g + 1) % NUM_DIMS;
            always_ff @(posedge i_clk) begin
                if (r_state == S_SQ) begin
                    r_point[g] <= r_point[NXT];
                end else if (w_acc_in && i_in_item.command &&
                             {25'd0, i_in_item.word_index} == 32'(g)) begin
                    r_point[g] <= i_in_item.word_value;
                end
            end
        end
    endgenerate

    // ---------------------------------------------------------------- head datapath
    logic signed [31:0] w_v;
    logic signed [31:0] w_w;
    logic [30:0]        w_v31;
    logic [34:0]        w_v12;
    logic signed [32:0] w_diff;
    t_qres              w_dsat;
    logic [31:0]        w_mag;
    logic [63:0]        w_sq;
    logic [31:0]        w_r2;
    logic               w_ge;
    logic [31:0]        w_r2sub;
    logic [32:0]        w_hprod;
    logic [52:0]        w_hq;
    logic [33:0]        w_eprod;
    logic signed [31:0] w_e32;
    logic signed [31:0] w_negk;
    logic signed [31:0] w_mul_a, w_mul_b;
    t_qres              w_mq;
    t_qres              w_ssat;
    logic               w_axis_ok;
    logic signed [AW-1:0] w_mq_ext;

    assign w_v      = $signed(w_var[0]);
    assign w_w      = $signed(w_wt[0]);
    assign w_v31    = w_var[0][30:0];
    assign w_v12    = {1'b0, w_v31, 3'b000} + {2'b00, w_v31, 2'b00};
    assign w_diff   = {r_point[0][31], r_point[0]} - {w_center[0][0][31], w_center[0][0]};
    assign w_dsat   = sat33(w_diff);
    assign w_mag    = r_d[32] ? 32'(-r_d) : r_d[31:0];
    assign w_sq     = w_mag * w_mag;
    assign w_r2     = {r_rem, r_low[19]};
    assign w_ge     = (w_r2 >= {1'b0, w_v31});
    assign w_r2sub  = w_r2 - {1'b0, w_v31};
    assign w_hprod  = {17'd0, r_quo[15:0]} * {16'd0, r_acc};
    assign w_hq     = 53'(r_prod[32:16]) * 53'(recip_tab(r_j));
    assign w_eprod  = {17'd0, exp_tab(r_quo[19:16])} * {17'd0, r_acc};
    assign w_e32    = {15'd0, r_e};
    assign w_negk   = -$signed({1'b0, r_quo});
    assign w_axis_ok = {30'd0, i_in_item.deriv_axis} < 32'(NUM_DIMS);

    // one shared Q16.16 multiplier, operands picked by the current step
    always_comb begin
        w_mul_a = w_w;
        w_mul_b = w_e32;
        if (r_state == S_MD) begin
            case (r_step)
                M_P:     begin w_mul_a = w_negk; w_mul_b = r_diffa; end
                M_EP:    begin w_mul_a = w_e32;  w_mul_b = r_p;     end
                M_S1:    begin w_mul_a = w_w;    w_mul_b = r_tmp;   end
                M_PP:    begin w_mul_a = r_p;    w_mul_b = r_p;     end
                M_ES:    begin w_mul_a = w_e32;  w_mul_b = r_tmp;   end
                M_S2:    begin w_mul_a = w_w;    w_mul_b = r_tmp;   end
                default: begin w_mul_a = w_w;    w_mul_b = w_e32;   end
            endcase
        end
    end

    assign w_mq     = qmul(w_mul_a, w_mul_b);
    assign w_ssat   = sat33({w_mq.val[31], w_mq.val} - {2'b00, r_quo});
    assign w_mq_ext = {{(AW-32){w_mq.val[31]}}, w_mq.val};

    // saturate an accumulator to 32 bits, flag in the top bit
    function automatic logic [32:0] sat_acc(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = {{(AW-32){1'b0}}, 32'h7FFF_FFFF};
        lo = {{(AW-32){1'b1}}, 32'h8000_0000};
        if (x > hi) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (x < lo) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, x[31:0]};
    endfunction

    logic [32:0] w_o0, w_o1, w_o2;
    assign w_o0 = sat_acc(r_s0);
    assign w_o1 = sat_acc(r_s1);
    assign w_o2 = sat_acc(r_s2);

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken; the final state loads a new one itself
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in && i_in_item.command && i_in_item.last_coordinate) begin
                        r_axis    <= i_in_item.deriv_axis;
                        r_axis_ok <= w_axis_ok;
                        r_flag    <= 1'b0;
                        r_s0      <= '0;
                        r_s1      <= '0;
                        r_s2      <= '0;
                        r_unit    <= '0;
                        r_state   <= S_UNIT;
                    end
                end
                S_UNIT: begin
                    r_dim   <= '0;
                    r_d2    <= '0;
                    r_diffa <= '0;
                    if (w_v <= 32'sd0) begin
                        // nonpositive variance: no contribution, raise the flag
                        r_flag  <= 1'b1;
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_d <= {w_dsat.val[31], w_dsat.val};
                    if (w_dsat.ovf) begin
                        r_flag <= 1'b1;
                    end
                    if (r_axis_ok && r_dim == DCW'(r_axis)) begin
                        r_diffa <= w_dsat.val;
                    end
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_d2  <= r_d2 + D2W'(w_sq[63:16]);
                    r_dim <= r_dim + 1'b1;
                    if (r_dim == DCW'(NUM_DIMS - 1)) begin
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_CMP: begin
                    if (r_d2 >= D2W'(w_v12)) begin
                        r_e     <= '0;
                        r_state <= S_K;
                    end else begin
                        // partial remainder d2 >> 4 stays below v here
                        r_rem   <= r_d2[34:4];
                        r_low   <= {r_d2[3:0], 16'd0};
                        r_quo   <= '0;
                        r_cnt   <= 5'd20;
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV, S_KDIV: begin
                    r_rem <= w_ge ? w_r2sub[30:0] : w_r2[30:0];
                    r_quo <= {r_quo[29:0], w_ge};
                    r_low <= {r_low[18:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 5'd1) begin
                        if (r_state == S_TDIV) begin
                            r_acc   <= 17'd65536;
                            r_j     <= 4'd10;
                            r_state <= S_HMUL;
                        end else begin
                            r_state <= S_M0;
                        end
                    end
                end
                S_HMUL: begin
                    r_prod  <= w_hprod;
                    r_state <= S_HDIV;
                end
                S_HDIV: begin
                    r_acc <= 17'd65536 - w_hq[51:35];
                    r_j   <= r_j - 1'b1;
                    if (r_j == 4'd1) begin
                        r_state <= S_EXP;
                    end else begin
                        r_state <= S_HMUL;
                    end
                end
                S_EXP: begin
                    r_e     <= w_eprod[32:16];
                    r_state <= S_K;
                end
                S_K: begin
                    if (!r_axis_ok) begin
                        r_state <= S_M0;
                    end else if (w_v31 <= 31'd4) begin
                        // 2/v does not fit: clamp and flag
                        r_quo   <= 31'h7FFF_FFFF;
                        r_flag  <= 1'b1;
                        r_state <= S_M0;
                    end else begin
                        r_rem   <= 31'd4;
                        r_low   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= 5'd31;
                        r_state <= S_KDIV;
                    end
                end
                S_M0: begin
                    r_s0 <= r_s0 + w_mq_ext;
                    if (w_mq.ovf) begin
                        r_flag <= 1'b1;
                    end
                    r_step  <= M_P;
                    r_state <= r_axis_ok ? S_MD : S_NEXT;
                end
                S_MD: begin
                    if (w_mq.ovf || (r_step == M_PP && w_ssat.ovf)) begin
                        r_flag <= 1'b1;
                    end
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        M_P:  r_p   <= w_mq.val;
                        M_EP: r_tmp <= w_mq.val;
                        M_S1: r_s1  <= r_s1 + w_mq_ext;
                        M_PP: r_tmp <= w_ssat.val;
                        M_ES: r_tmp <= w_mq.val;
                        M_S2: begin
                            r_s2    <= r_s2 + w_mq_ext;
                            r_state <= S_NEXT;
                        end
                        default: r_state <= S_NEXT;
                    endcase
                end
                S_NEXT: begin
                    // advance the ring so the next unit reaches the head
                    r_unit <= r_unit + 1'b1;
                    if (r_unit == UCW'(NUM_UNITS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_UNIT;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.model_value       <= w_o0[31:0];
                        r_out.first_derivative  <= w_o1[31:0];
                        r_out.second_derivative <= w_o2[31:0];
                        r_out.overflow_flag     <= r_flag | w_o0[32] | w_o1[32] | w_o2[32];
                        r_out_valid             <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ===== sv/rbf_cell.sv =====
// One network unit: center row, variance and weight, in a rotating ring.
`default_nettype none
module rbf_cell import rbf_pkg::*; #(
    parameter int NUM_UNITS = NUM_UNITS_DEF,
    parameter int NUM_DIMS  = NUM_DIMS_DEF,
    parameter int ID        = 0
) (
    input  wire logic                           i_clk,
    input  wire t_cell_ctl                      i_ctl,
    input  wire logic [NUM_DIMS-1:0][31:0]      i_nb_center,
    input  wire logic [31:0]                    i_nb_var,
    input  wire logic [31:0]                    i_nb_wt,
    output logic      [NUM_DIMS-1:0][31:0]      o_center,
    output logic      [31:0]                    o_var,
    output logic      [31:0]                    o_wt
);
    localparam int NC = NUM_UNITS * NUM_DIMS;

    logic [NUM_DIMS-1:0][31:0] r_center;
    logic [31:0]               r_var;
    logic [31:0]               r_wt;
    logic [31:0]               w_idx;

    assign w_idx = {25'd0, i_ctl.idx};

    genvar g;
    generate
        for (g = 0; g < NUM_DIMS; g++) begin : g_dim
            localparam int NXT = (g + 1) % NUM_DIMS;
            always_ff @(posedge i_clk) begin
                if (i_ctl.shift) begin
                    r_center[g] <= i_nb_center[g];
                end else if (i_ctl.rot) begin
                    r_center[g] <= r_center[NXT];
                end else if (i_ctl.we && w_idx == 32'(ID * NUM_DIMS + g)) begin
                    r_center[g] <= i_ctl.data;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_var <= i_nb_var;
            r_wt  <= i_nb_wt;
        end else begin
            if (i_ctl.we && w_idx == 32'(NC + ID)) begin
                r_var <= i_ctl.data;
            end
            if (i_ctl.we && w_idx == 32'(NC + NUM_UNITS + ID)) begin
                r_wt <= i_ctl.data;
            end
        end
    end

    assign o_center = r_center;
    assign o_var    = r_var;
    assign o_wt     = r_wt;

endmodule
`default_nettype wire

// ===== sv/rbf_checker.sv =====
// Port-level checker for the evaluator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rbf_checker import rbf_pkg::*; (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_stall,
    input wire t_in_item i_in_item,
    input wire logic     o_out_valid,
    input wire logic     i_out_stall
);
    `RBF_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `RBF_ASSERT(a_eval_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_item.command && i_in_item.last_coordinate |=> o_in_stall, "evaluation item did not stall input")
    `RBF_ASSERT(a_load_free, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_in_item.command |=> !o_in_stall, "load item stalled input")
    `RBF_ASSERT(a_res_src, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result without evaluation")
endmodule

bind gaussian_rbf_network_eval_core rbf_checker u_rbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
`default_nettype wire

// ===== tb/sv/gaussian_rbf_network_eval_core_tb.sv =====
// Self-checking testbench for the Gaussian RBF network evaluation core.
`timescale 1ns / 100ps
`default_nettype none
module gaussian_rbf_network_eval_core_tb;
    import rbf_pkg::*;

    localparam int  UNITS      = 16;
    localparam int  DIMS       = 4;
    localparam int  N_CENTER   = UNITS * DIMS;
    localparam int  N_WORDS    = N_CENTER + 2 * UNITS;
    localparam int  TAIL_WAIT  = 3000;
    localparam int  CYCLE_CAP  = 4000000;
    localparam logic CMD_MODEL = 1'b0;
    localparam logic CMD_COORD = 1'b1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    gaussian_rbf_network_eval_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    // Shadow copy of the model and point, updated as items are accepted.
    logic signed [31:0] center_mem [N_CENTER];
    logic signed [31:0] var_mem    [UNITS];
    logic signed [31:0] weight_mem [UNITS];
    logic signed [31:0] point_mem  [DIMS];

    t_in_item  pending_items[$];
    t_out_item eval_results[$];
    int        cyc = 0;
    int        mismatch_count = 0;
    int        eval_count = 0;
    int        load_count = 0;
    int        flagged_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // A 21 in 100 chance of idling, except for one quiet stretch with no idling.
    function automatic bit idle_roll();
        if (cyc >= 20000 && cyc < 70000) return 1'b0;
        return $urandom_range(0, 99) < 21;
    endfunction

    function automatic longint clamp32(longint v, inout bit f);
        if (v > 64'sd2147483647) begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            f = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 multiply on magnitudes, truncate toward zero, saturate with flag.
    function automatic longint q_mult(longint a, longint b, inout bit f);
        bit              neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned pr;
        neg = (a < 0) != (b < 0);
        ma  = a < 0 ? longint'(-a) : a;
        mb  = b < 0 ? longint'(-b) : b;
        pr  = (ma * mb) >> 16;
        if (neg) begin
            if (pr > 64'h8000_0000) begin
                f = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(pr);
        end
        if (pr > 64'h7FFF_FFFF) begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(pr);
    endfunction

    // exp(-d2/v): integer part from a table, fraction by ten Horner steps.
    function automatic longint unsigned gauss_term(longint unsigned d2, longint unsigned v);
        longint unsigned tab [12];
        longint unsigned t;
        longint unsigned fr;
        longint unsigned acc;
        tab = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
        if (d2 >= 12 * v) return 0;
        t   = (d2 << 16) / v;
        fr  = t & 64'hFFFF;
        acc = 65536;
        for (longint unsigned j = 10; j >= 1; j--)
            acc = 65536 - ((fr * acc) >> 16) / j;
        return (tab[(t >> 16) % 12] * acc) >> 16;
    endfunction

    function automatic t_out_item rbf_predict(logic [1:0] axis);
        bit              f;
        longint          s0;
        longint          s1;
        longint          s2;
        longint          v;
        longint          w;
        longint          e;
        longint          k;
        longint          p;
        longint          sq;
        longint          ep;
        longint          d;
        longint          diff_a;
        longint unsigned d2;
        longint unsigned m;
        longint unsigned kk;
        t_out_item       r;
        f = 1'b0;
        s0 = 0;
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < UNITS; i++) begin
            v = var_mem[i];
            w = weight_mem[i];
            if (v <= 0) begin
                f = 1'b1;
                continue;
            end
            d2 = 0;
            diff_a = 0;
            for (int j = 0; j < DIMS; j++) begin
                d = clamp32(longint'(point_mem[j]) - longint'(center_mem[i * DIMS + j]), f);
                m = d < 0 ? longint'(-d) : d;
                d2 += (m * m) >> 16;
                if (j == axis) diff_a = d;
            end
            e = longint'(gauss_term(d2, v));
            s0 += q_mult(w, e, f);
            // the axis field always names a valid dimension at four dimensions
            kk = (64'd1 << 33) / longint'(v);
            if (kk > 64'h7FFF_FFFF) begin
                f = 1'b1;
                kk = 64'h7FFF_FFFF;
            end
            k = kk;
            p = q_mult(-k, diff_a, f);
            ep = q_mult(e, p, f);
            s1 += q_mult(w, ep, f);
            sq = q_mult(p, p, f);
            sq = clamp32(sq - k, f);
            ep = q_mult(e, sq, f);
            s2 += q_mult(w, ep, f);
        end
        s0 = clamp32(s0, f);
        s1 = clamp32(s1, f);
        s2 = clamp32(s2, f);
        r.model_value       = s0[31:0];
        r.first_derivative  = s1[31:0];
        r.second_derivative = s2[31:0];
        r.overflow_flag     = f;
        return r;
    endfunction

    // Apply one accepted item to the shadow state and queue any result it causes.
    task automatic absorb_item(t_in_item it);
        if (it.command == CMD_MODEL) begin
            if (it.word_index < N_CENTER)
                center_mem[it.word_index] = it.word_value;
            else if (it.word_index < N_CENTER + UNITS)
                var_mem[it.word_index - N_CENTER] = it.word_value;
            else if (it.word_index < N_WORDS)
                weight_mem[it.word_index - N_CENTER - UNITS] = it.word_value;
            load_count++;
        end else begin
            if (it.word_index < DIMS) point_mem[it.word_index] = it.word_value;
            if (it.last_coordinate) begin
                eval_results.push_back(rbf_predict(it.deriv_axis));
                eval_count++;
            end
        end
    endtask

    // Driver: hold a stalled item, otherwise advance to the next pending one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && o_in_stall)) begin
            if (in_valid) absorb_item(in_item);
            if (pending_items.size() > 0 && !idle_roll()) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, compare each accepted result with the oldest one due.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (eval_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected result %h at cycle %0d", o_out_item, cyc);
                end else begin
                    t_out_item want;
                    want = eval_results.pop_front();
                    if (o_out_item.overflow_flag) flagged_count++;
                    if (want.model_value !== o_out_item.model_value ||
                        want.first_derivative !== o_out_item.first_derivative ||
                        want.second_derivative !== o_out_item.second_derivative ||
                        want.overflow_flag !== o_out_item.overflow_flag) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: cycle %0d value %h/%h d1 %h/%h d2 %h/%h ovf %b/%b",
                                     cyc, want.model_value, o_out_item.model_value,
                                     want.first_derivative, o_out_item.first_derivative,
                                     want.second_derivative, o_out_item.second_derivative,
                                     want.overflow_flag, o_out_item.overflow_flag);
                    end
                end
            end
            out_stall <= idle_roll();
        end
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP) begin
            $display("timeout at cycle %0d, %0d results outstanding", cyc, eval_results.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_in_item pack_item(logic cmd, int idx, logic [31:0] val,
                                           logic last, logic [1:0] axis);
        t_in_item it;
        it.command         = cmd;
        it.word_index      = idx[6:0];
        it.word_value      = val;
        it.last_coordinate = last;
        it.deriv_axis      = axis;
        return it;
    endfunction

    // Mostly modest magnitudes (within +-4.0), now and then any 32-bit pattern.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 19) == 0) return $urandom();
        return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
    endfunction

    function automatic logic [31:0] rand_model_word(int idx);
        int pick;
        if (idx < N_CENTER || idx >= N_CENTER + UNITS) return rand_coord();
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(32'h4000, 32'h8_0000);
        if (pick < 76) return 32'h0;
        if (pick < 82) return 32'h8000_0000 | $urandom();
        if (pick < 88) return $urandom_range(1, 4);
        if (pick < 94) return 32'h7FFF_FFFF;
        return $urandom();
    endfunction

    task automatic push_random_item();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            idx = $urandom_range(0, N_WORDS - 1);
            pending_items.push_back(pack_item(CMD_MODEL, idx, rand_model_word(idx),
                                              1'($urandom_range(0, 1)),
                                              2'($urandom_range(0, 3))));
        end else if (pick < 40) begin
            // index past the model layout: dropped by the block
            pending_items.push_back(pack_item(CMD_MODEL, $urandom_range(N_WORDS, 127),
                                              $urandom(), 1'($urandom_range(0, 1)),
                                              2'($urandom_range(0, 3))));
        end else if (pick < 75) begin
            pending_items.push_back(pack_item(CMD_COORD, $urandom_range(0, DIMS - 1),
                                              rand_coord(), $urandom_range(0, 5) == 0,
                                              2'($urandom_range(0, 3))));
        end else if (pick < 80) begin
            // coordinate index out of range, evaluation may still follow
            pending_items.push_back(pack_item(CMD_COORD, $urandom_range(DIMS, 127),
                                              $urandom(), 1'($urandom_range(0, 1)),
                                              2'($urandom_range(0, 3))));
        end else begin
            // well-formed point: every coordinate, the last one triggers evaluation
            for (int j = 0; j < DIMS; j++)
                pending_items.push_back(pack_item(CMD_COORD, j, rand_coord(), j == DIMS - 1,
                                                  2'($urandom_range(0, 3))));
        end
    endtask

    task automatic drain_all();
        while (pending_items.size() > 0 || in_valid || eval_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every model word so nothing is read before it is written.
        for (int i = 0; i < N_WORDS; i++)
            pending_items.push_back(pack_item(CMD_MODEL, i, rand_coord(), 1'b0, 2'd0));
        for (int u = 0; u < UNITS; u++)
            pending_items.push_back(pack_item(CMD_MODEL, N_CENTER + u,
                                              $urandom_range(32'h8000, 32'h4_0000), 1'b0, 2'd0));
        // Special variances: zero, negative, tiny (reciprocal clamps), largest; then extreme weights.
        pending_items.push_back(pack_item(CMD_MODEL, N_CENTER + 3, 32'h0, 1'b0, 2'd0));
        pending_items.push_back(pack_item(CMD_MODEL, N_CENTER + 5, 32'h8000_0000, 1'b0, 2'd0));
        pending_items.push_back(pack_item(CMD_MODEL, N_CENTER + 7, 32'h1, 1'b0, 2'd0));
        pending_items.push_back(pack_item(CMD_MODEL, N_CENTER + 9, 32'h7FFF_FFFF, 1'b0, 2'd0));
        pending_items.push_back(pack_item(CMD_MODEL, N_WORDS - 1, 32'h7FFF_FFFF, 1'b0, 2'd0));
        pending_items.push_back(pack_item(CMD_MODEL, N_CENTER + UNITS, 32'h8000_0000,
                                          1'b0, 2'd0));
        // Near point, every axis.
        for (int a = 0; a < 4; a++)
            for (int j = 0; j < DIMS; j++)
                pending_items.push_back(pack_item(CMD_COORD, j, rand_coord(), j == DIMS - 1,
                                                  a[1:0]));
        // Extreme coordinates against extreme centers: differences clamp.
        pending_items.push_back(pack_item(CMD_MODEL, 0, 32'h8000_0000, 1'b0, 2'd0));
        pending_items.push_back(pack_item(CMD_MODEL, 1, 32'h7FFF_FFFF, 1'b0, 2'd0));
        pending_items.push_back(pack_item(CMD_COORD, 0, 32'h7FFF_FFFF, 1'b0, 2'd0));
        pending_items.push_back(pack_item(CMD_COORD, 1, 32'h8000_0000, 1'b1, 2'd1));
        // Ignored items, then an out-of-range coordinate that still evaluates.
        pending_items.push_back(pack_item(CMD_MODEL, 127, 32'hFFFF_FFFF, 1'b1, 2'd3));
        pending_items.push_back(pack_item(CMD_MODEL, N_WORDS, 32'h0, 1'b1, 2'd2));
        pending_items.push_back(pack_item(CMD_COORD, 127, 32'hFFFF_FFFF, 1'b1, 2'd3));

        // Hold the sender until every result is back.
        drain_all();
        for (int n = 0; n < 256; n++) begin
            push_random_item();
            if (n == 128) drain_all();
        end

        drain_all();
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("Covered %0d model loads and %0d evaluations (%0d flagged) in %0d cycles.",
                 load_count, eval_count, flagged_count, cyc);
        if (mismatch_count == 0 && eval_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     eval_results.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== gaussian_rbf_network_eval_core.f =====
+incdir+sv
sv/rbf_pkg.sv
sv/rbf_cell.sv
sv/gaussian_rbf_network_eval_core.sv
sv/rbf_checker.sv
tb/sv/gaussian_rbf_network_eval_core_tb.sv
